FILE: rtl/core/rk4_pkg.sv
`default_nettype none

package rk4_pkg;

    localparam int unsigned Q_WIDTH = 32;

    typedef logic signed [Q_WIDTH-1:0] q_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // Status codes on the final point of a run.
    localparam logic [1:0] ST_REACHED = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;

    typedef struct packed {
        logic start;
        q_t   a;
        q_t   b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        q_t   prod;
    } mul_rsp_t;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic q_t sat33(input logic signed [Q_WIDTH:0] v);
        q_t r;
        if (v[Q_WIDTH] != v[Q_WIDTH-1]) begin
            r = v[Q_WIDTH] ? Q_MIN : Q_MAX;
        end else begin
            r = v[Q_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rk4_mul.sv
`default_nettype none

// Signed fixed-point multiplier, radix-16 serial: one 4-bit digit of b per cycle.
// The product is floored by FRAC_BITS and saturated to 32 bits.
module rk4_mul
    import rk4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam int HI_W = Q_WIDTH + 4;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [2:0]              cnt_reg, cnt_next;
    q_t                      a_reg, a_next;
    logic signed [HI_W-1:0]  hi_reg, hi_next;
    logic [Q_WIDTH-1:0]      lo_reg, lo_next;

    logic signed [4:0]       digit;
    logic signed [HI_W:0]    sum;
    logic [2*Q_WIDTH-1:0]    full;
    logic [Q_WIDTH-FRAC_BITS:0] top;
    logic                    ovf;

    always_comb begin
        // The top digit of b carries its sign; the others are unsigned.
        digit = (cnt_reg == 3'd7) ? {lo_reg[3], lo_reg[3:0]} : {1'b0, lo_reg[3:0]};
        sum   = (HI_W+1)'(hi_reg) + (HI_W+1)'(a_reg) * (HI_W+1)'(digit);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            a_next    = req.a;
            hi_next   = '0;
            lo_next   = req.b;
        end else if (busy_reg) begin
            hi_next  = HI_W'(sum >>> 4);
            lo_next  = {sum[3:0], lo_reg[Q_WIDTH-1:4]};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    always_comb begin
        full     = {hi_reg[Q_WIDTH-1:0], lo_reg};
        top      = full[2*Q_WIDTH-1:Q_WIDTH+FRAC_BITS-1];
        ovf      = !(&top) && (|top);
        rsp.done = done_reg;
        if (ovf) begin
            rsp.prod = full[2*Q_WIDTH-1] ? Q_MIN : Q_MAX;
        end else begin
            rsp.prod = full[Q_WIDTH+FRAC_BITS-1:FRAC_BITS];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rk4_ode_integrator.sv
`default_nettype none

// Channel  | Ports                          | Payload
// ---------+--------------------------------+-----------------------------------------
// input    | s_tvalid s_tready s_tdata      | start_x, start_y, target_x
// result   | m_tvalid m_tready m_tdata ...  | point_x, point_y; tlast = last; tuser = status
// config   | cfg_valid cfg_ready cfg_data   | step_size
//
// One RK4 step takes twelve multiplies on the shared radix-16 serial multiplier; an item
// takes up to MAX_POINTS-1 steps. A step size write forms h/6 bit-serially. Reset is
// synchronous, active low, and restores step 0.25. A point waits in the output register;
// work stalls only when a second point is ready.
module rk4_ode_integrator
    import rk4_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // start_x, start_y, target_x
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // point_x, point_y
    output logic             m_tlast,
    output logic [1:0]       m_tuser,   // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [30:0] cfg_data   // step_size
);

    localparam int          NW         = $clog2(MAX_POINTS);
    localparam logic [30:0] STEP_RESET = 31'd16384;
    localparam logic [30:0] H6_RESET   = STEP_RESET / 6;
    localparam q_t          Q_ONE      = q_t'(1) <<< FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_MXX  = 3'd3;
    localparam logic [2:0] S_MXY  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_MH   = 3'd6;
    localparam logic [2:0] S_MK   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [30:0]   h_reg, h_next;
    logic [30:0]   h6_reg, h6_next;
    logic [4:0]    dcnt_reg, dcnt_next;
    logic [2:0]    rem_reg, rem_next;
    logic [NW-1:0] n_reg, n_next;
    logic [1:0]    stage_reg, stage_next;
    q_t            x_reg, x_next;
    q_t            y_reg, y_next;
    q_t            t_reg, t_next;
    q_t            px_reg, px_next;
    q_t            py_reg, py_next;
    q_t            m_reg, m_next;
    q_t            k_reg, k_next;
    mul_req_t      req_reg, req_next;
    mul_rsp_t      rsp;

    logic          ov_reg, ov_next;
    q_t            ox_reg, ox_next;
    q_t            oy_reg, oy_next;
    logic          ol_reg, ol_next;
    logic [1:0]    os_reg, os_next;

    logic [3:0]                 rtrial;
    logic signed [Q_WIDTH:0]    nx;
    q_t                         x_hh, x_h, t2, m2x, delta;
    logic                       out_free;

    rk4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    always_comb begin
        rtrial   = {rem_reg, h_reg[dcnt_reg]};
        nx       = {x_reg[Q_WIDTH-1], x_reg} + {2'b00, h_reg};
        x_hh     = sat33({x_reg[Q_WIDTH-1], x_reg} + {3'b000, h_reg[30:1]});
        x_h      = sat33(nx);
        t2       = sat33({rsp.prod, 1'b0});
        m2x      = sat33({m_reg, 1'b0});
        delta    = (stage_reg == 2'd2) ? rsp.prod : (rsp.prod >>> 1);
        out_free = !ov_reg || m_tready;

        state_next = state_reg;
        h_next     = h_reg;
        h6_next    = h6_reg;
        dcnt_next  = dcnt_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        stage_next = stage_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        req_next   = req_reg;
        req_next.start = 1'b0;

        ov_next = ov_reg && !m_tready;
        ox_next = ox_reg;
        oy_next = oy_reg;
        ol_next = ol_reg;
        os_next = os_reg;

        case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    h_next     = cfg_data;
                    dcnt_next  = 5'd30;
                    rem_next   = '0;
                    state_next = S_DIV;
                end else if (s_tvalid) begin
                    x_next     = s_tdata[31:0];
                    y_next     = s_tdata[63:32];
                    t_next     = s_tdata[95:64];
                    n_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                // Restoring division by six, one quotient bit a cycle.
                if (rtrial >= 4'd6) begin
                    rem_next = 3'(rtrial - 4'd6);
                    h6_next  = {h6_reg[29:0], 1'b1};
                end else begin
                    rem_next = rtrial[2:0];
                    h6_next  = {h6_reg[29:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ox_next = x_reg;
                    oy_next = y_reg;
                    ol_next = 1'b1;
                    if (x_reg > t_reg) begin
                        os_next = ST_BEYOND;
                    end else if (x_reg == t_reg ||
                                 nx > $signed({t_reg[Q_WIDTH-1], t_reg})) begin
                        os_next = ST_REACHED;
                    end else if (n_reg == NW'(MAX_POINTS - 1)) begin
                        os_next = ST_LIMIT;
                    end else begin
                        os_next = ST_REACHED;
                        ol_next = 1'b0;
                    end
                    if (ol_next) begin
                        state_next = S_IDLE;
                    end else begin
                        n_next         = n_reg + NW'(1);
                        stage_next     = 2'd0;
                        px_next        = x_reg;
                        py_next        = y_reg;
                        req_next.start = 1'b1;
                        req_next.a     = x_reg;
                        req_next.b     = x_reg;
                        state_next     = S_MXX;
                    end
                end
            end
            S_MXX: begin
                if (rsp.done) begin
                    req_next.start = 1'b1;
                    req_next.a     = rsp.prod;
                    req_next.b     = py_reg;
                    state_next     = S_MXY;
                end
            end
            S_MXY: begin
                if (rsp.done) begin
                    m_next     = sat33({Q_ONE[Q_WIDTH-1], Q_ONE} - {t2[Q_WIDTH-1], t2});
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                req_next.start = 1'b1;
                if (stage_reg == 2'd0) begin
                    k_next = m_reg;
                end else if (stage_reg == 2'd3) begin
                    k_next = sat33({k_reg[Q_WIDTH-1], k_reg} + {m_reg[Q_WIDTH-1], m_reg});
                end else begin
                    k_next = sat33({k_reg[Q_WIDTH-1], k_reg} + {m2x[Q_WIDTH-1], m2x});
                end
                if (stage_reg == 2'd3) begin
                    req_next.a = {1'b0, h6_reg};
                    req_next.b = k_next;
                    state_next = S_MK;
                end else begin
                    req_next.a = m_reg;
                    req_next.b = {1'b0, h_reg};
                    state_next = S_MH;
                end
            end
            S_MH: begin
                if (rsp.done) begin
                    stage_next     = stage_reg + 2'd1;
                    py_next        = sat33({y_reg[Q_WIDTH-1], y_reg} + {delta[Q_WIDTH-1], delta});
                    px_next        = (stage_reg == 2'd2) ? x_h : x_hh;
                    req_next.start = 1'b1;
                    req_next.a     = px_next;
                    req_next.b     = px_next;
                    state_next     = S_MXX;
                end
            end
            S_MK: begin
                if (rsp.done) begin
                    y_next     = sat33({y_reg[Q_WIDTH-1], y_reg} +
                                       {rsp.prod[Q_WIDTH-1], rsp.prod});
                    x_next     = nx[Q_WIDTH-1:0];
                    state_next = S_EMIT;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            h_reg         <= STEP_RESET;
            h6_reg        <= H6_RESET;
            ov_reg        <= 1'b0;
            req_reg.start <= 1'b0;
        end else begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            h6_reg        <= h6_next;
            ov_reg        <= ov_next;
            req_reg.start <= req_next.start;
        end
        req_reg.a <= req_next.a;
        req_reg.b <= req_next.b;
        dcnt_reg  <= dcnt_next;
        rem_reg   <= rem_next;
        n_reg     <= n_next;
        stage_reg <= stage_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        t_reg     <= t_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ol_reg    <= ol_next;
        os_reg    <= os_next;
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {oy_reg, ox_reg};
    assign m_tlast   = ol_reg;
    assign m_tuser   = os_reg;

endmodule

`default_nettype wire
